### rtl/cls_pkg.sv
// Shared types, constants and the control program for the combined LCG shuffle generator.
// Used by cls_useq, cls_table and combined_lcg_shuffle_rng; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

   // Generator word, seed word and product widths
   localparam int CLS_GEN_W  = 31;
   localparam int CLS_SEED_W = 32;
   localparam int CLS_MUL_W  = 16;
   localparam int CLS_PROD_W = CLS_GEN_W + CLS_MUL_W;

   localparam int CLS_TABLE_SIZE = 32;

   // Moduli, multipliers and the folding constants 2^31 mod m
   localparam logic [CLS_GEN_W-1:0] CLS_MOD_A   = 31'd2147483563;
   localparam logic [CLS_GEN_W-1:0] CLS_MOD_B   = 31'd2147483399;
   localparam logic [CLS_MUL_W-1:0] CLS_MUL_A   = 16'd40014;
   localparam logic [CLS_MUL_W-1:0] CLS_MUL_B   = 16'd40692;
   localparam logic [7:0]           CLS_FOLD_A  = 8'd85;
   localparam logic [7:0]           CLS_FOLD_B  = 8'd249;
   localparam logic [CLS_GEN_W-1:0] CLS_OUT_MAX = 31'd2147483562;
   localparam logic [CLS_GEN_W-1:0] CLS_GEN_B_INIT = 31'd123456789;

   // Multiplier operand selects
   typedef enum logic [1:0] {
      BIG_FG,
      BIG_SG,
      BIG_LAST,
      BIG_BUCKET
   } cls_big_sel_type;

   typedef enum logic [1:0] {
      SML_MUL_A,
      SML_MUL_B,
      SML_RECIP,
      SML_QEST
   } cls_small_sel_type;

   // Write-back operations
   typedef enum logic [2:0] {
      WB_NONE,
      WB_SEED,
      WB_WARM,
      WB_GEN_A,
      WB_GEN_B,
      WB_OUT
   } cls_wb_type;

   // Table index operations
   typedef enum logic [1:0] {
      Q_HOLD,
      Q_EST,
      Q_FIX
   } cls_qop_type;

   localparam int CLS_PC_W = 4;

   // Program step addresses; fall-through order matters
   localparam logic [CLS_PC_W-1:0] CLS_PC_SEED_LOAD  = 4'd0;
   localparam logic [CLS_PC_W-1:0] CLS_PC_WARM_MUL   = 4'd1;
   localparam logic [CLS_PC_W-1:0] CLS_PC_WARM_FOLD  = 4'd2;
   localparam logic [CLS_PC_W-1:0] CLS_PC_WARM_WB    = 4'd3;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_RECIP = 4'd4;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_MULA  = 4'd5;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_BKT   = 4'd6;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_FIX   = 4'd7;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_FOLDB = 4'd8;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_SWAP  = 4'd9;
   localparam logic [CLS_PC_W-1:0] CLS_PC_DRAW_OUT   = 4'd10;

   typedef struct packed {
      logic                  prod_en;
      cls_big_sel_type       big_sel;
      cls_small_sel_type     small_sel;
      logic                  fold_en;
      logic                  fold_b;
      cls_wb_type            wb;
      cls_qop_type           q_op;
      logic                  tbl_rd;
      logic                  tbl_wr;
      logic                  loop;
      logic [CLS_PC_W-1:0]   target;
      logic                  done;
   } cls_ctl_type;

   localparam cls_ctl_type CLS_CTL_NOP = '{
      prod_en:   1'b0,
      big_sel:   BIG_FG,
      small_sel: SML_MUL_A,
      fold_en:   1'b0,
      fold_b:    1'b0,
      wb:        WB_NONE,
      q_op:      Q_HOLD,
      tbl_rd:    1'b0,
      tbl_wr:    1'b0,
      loop:      1'b0,
      target:    CLS_PC_SEED_LOAD,
      done:      1'b0
   };

   // Control store: one word per step
   function automatic cls_ctl_type cls_ucode(input logic [CLS_PC_W-1:0] pc);
      cls_ctl_type w;
      w = CLS_CTL_NOP;
      case (pc)
         CLS_PC_SEED_LOAD: begin
            w.wb = WB_SEED;
         end
         CLS_PC_WARM_MUL: begin
            w.prod_en   = 1'b1;
            w.big_sel   = BIG_FG;
            w.small_sel = SML_MUL_A;
         end
         CLS_PC_WARM_FOLD: begin
            w.fold_en = 1'b1;
            w.fold_b  = 1'b0;
         end
         CLS_PC_WARM_WB: begin
            w.wb     = WB_WARM;
            w.loop   = 1'b1;
            w.target = CLS_PC_WARM_MUL;
            w.done   = 1'b1;
         end
         CLS_PC_DRAW_RECIP: begin
            w.prod_en   = 1'b1;
            w.big_sel   = BIG_LAST;
            w.small_sel = SML_RECIP;
         end
         CLS_PC_DRAW_MULA: begin
            w.q_op      = Q_EST;
            w.prod_en   = 1'b1;
            w.big_sel   = BIG_FG;
            w.small_sel = SML_MUL_A;
         end
         CLS_PC_DRAW_BKT: begin
            w.prod_en   = 1'b1;
            w.big_sel   = BIG_BUCKET;
            w.small_sel = SML_QEST;
            w.fold_en   = 1'b1;
            w.fold_b    = 1'b0;
         end
         CLS_PC_DRAW_FIX: begin
            w.wb        = WB_GEN_A;
            w.q_op      = Q_FIX;
            w.prod_en   = 1'b1;
            w.big_sel   = BIG_SG;
            w.small_sel = SML_MUL_B;
         end
         CLS_PC_DRAW_FOLDB: begin
            w.fold_en = 1'b1;
            w.fold_b  = 1'b1;
            w.tbl_rd  = 1'b1;
         end
         CLS_PC_DRAW_SWAP: begin
            w.wb     = WB_GEN_B;
            w.tbl_wr = 1'b1;
         end
         CLS_PC_DRAW_OUT: begin
            w.wb   = WB_OUT;
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/cls_useq.sv
// Step counter and control store sequencer for the combined LCG shuffle generator.
// Depends on cls_pkg for the control word type and the program.
`timescale 1ns / 1ps
`default_nettype none

module cls_useq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire logic                 go_draw,
   input  wire logic                 cnt_zero,
   output logic                      busy,
   output cls_pkg::cls_ctl_type      ctl
);
   import cls_pkg::*;

   logic [CLS_PC_W-1:0] pc_ff;
   logic [CLS_PC_W-1:0] pc_in;
   logic                busy_ff;
   logic                busy_in;
   cls_ctl_type         word;
   logic                take;

   assign word = cls_ucode(pc_ff);
   assign take = word.loop && !cnt_zero;
   assign ctl  = busy_ff ? word : CLS_CTL_NOP;
   assign busy = busy_ff;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (take) begin
            pc_in = word.target;
         end else if (word.done) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + CLS_PC_W'(1);
         end
      end else if (go) begin
         busy_in = 1'b1;
         pc_in   = go_draw ? CLS_PC_DRAW_RECIP : CLS_PC_SEED_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= CLS_PC_SEED_LOAD;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cls_table.sv
// Shuffle table: one write port, one registered read port, per-entry valid bits.
// Entries never written since reset read as zero. Depends on cls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cls_table #(
   parameter int TABLE_SIZE = cls_pkg::CLS_TABLE_SIZE
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0]    wr_addr,
   input  wire logic [cls_pkg::CLS_GEN_W-1:0]    wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0]    rd_addr,
   output logic [cls_pkg::CLS_GEN_W-1:0]         rd_data
);
   import cls_pkg::*;

   logic [CLS_GEN_W-1:0]  mem_ff [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] vld_ff;
   logic [CLS_GEN_W-1:0]  rd_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

`default_nettype wire

### rtl/combined_lcg_shuffle_rng.sv
// Top level of the combined LCG random generator with Bays-Durham shuffle.
// Depends on cls_pkg, cls_useq (control sequencer) and cls_table (shuffle table).
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Commands enter on the req_ ports: a word is taken at a rising edge where start
//   is high and busy is low. req_command 0 seeds from req_seed_value, 1 draws one
//   number. Draws return a word on rsp_random_value, marked by rsp_strobe for one
//   cycle; seeds return nothing. The receiver cannot stall: take the word when the
//   strobe is high.
// Timing
//   A draw keeps busy high through its steps and strobes its word in the first
//   cycle with busy low; the next command can be taken in that same cycle. A seed
//   keeps busy high while it loads both generators and runs TABLE_SIZE+8 warm-up
//   steps of the first generator. Both lengths come from the single shared 31x16
//   multiplier: each generator step is multiply, fold, reduce, and a draw needs
//   four products (index estimate, index check, and one step of each generator)
//   plus the registered table read.
// Reset
//   Clears the sequencer, the generators (first 0, second 123456789), the last
//   output and every table valid bit; unwritten entries read as zero, so draws
//   before any seed are deterministic.
module combined_lcg_shuffle_rng #(
   parameter int TABLE_SIZE = cls_pkg::CLS_TABLE_SIZE
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_command,
   input  wire logic signed [cls_pkg::CLS_SEED_W-1:0]  req_seed_value,
   output logic                                        rsp_strobe,
   output logic [cls_pkg::CLS_GEN_W-1:0]               rsp_random_value
);
   import cls_pkg::*;

   // Table geometry and the divide-by-bucket constants
   localparam int     IDX_W   = $clog2(TABLE_SIZE);
   localparam int     Q_W     = $clog2(TABLE_SIZE + 1);
   localparam int     WARMUP  = TABLE_SIZE + 8;
   localparam int     CNT_W   = $clog2(WARMUP);
   localparam int     BND_W   = CLS_GEN_W + 3;
   localparam longint BUCKET  = longint'(1) + longint'(CLS_OUT_MAX) / TABLE_SIZE;
   localparam longint TWO_GEN = longint'(1) << CLS_GEN_W;
   localparam longint RECIP   = TWO_GEN / BUCKET;

   localparam logic [CLS_GEN_W-1:0] BUCKET_V = CLS_GEN_W'(BUCKET);
   localparam logic [CLS_MUL_W-1:0] RECIP_V  = CLS_MUL_W'(RECIP);

   cls_ctl_type ctl;
   logic        go;
   logic        cnt_zero;

   // Generator state and datapath registers
   logic [CLS_GEN_W-1:0]  fg_ff, fg_in;
   logic [CLS_GEN_W-1:0]  sg_ff, sg_in;
   logic [CLS_GEN_W-1:0]  last_ff, last_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [CLS_SEED_W-1:0] seed_ff;
   logic [CLS_PROD_W-1:0] prod_ff, prod_in;
   logic [CLS_GEN_W:0]    fold_ff, fold_in;
   logic                  fold_b_ff;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // Combinational helpers
   logic [CLS_GEN_W-1:0]  big_opd;
   logic [CLS_MUL_W-1:0]  small_opd;
   logic [7:0]            fold_c;
   logic [23:0]           hi_mul;
   logic [CLS_GEN_W-1:0]  mod_sel;
   logic [CLS_GEN_W:0]    red_wide;
   logic [CLS_GEN_W-1:0]  red;
   logic [CLS_SEED_W-1:0] seed_neg;
   logic [CLS_SEED_W-1:0] seed_abs;
   logic [CLS_GEN_W-1:0]  seed_mag;
   logic [BND_W-1:0]      bnd;
   logic                  bump;
   logic [Q_W:0]          q_fix;
   logic [CLS_GEN_W-1:0]  tbl_rd_data;
   logic [CLS_GEN_W+1:0]  diff;
   logic [CLS_GEN_W+1:0]  diff_alt;
   logic [CLS_GEN_W-1:0]  y_val;
   logic                  tbl_wr_en;
   logic [IDX_W-1:0]      tbl_wr_addr;
   logic [CLS_GEN_W-1:0]  tbl_wr_data;

   assign go       = start && !busy;
   assign cnt_zero = (cnt_ff == '0);

   cls_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .go_draw  (req_command),
      .cnt_zero (cnt_zero),
      .busy     (busy),
      .ctl      (ctl)
   );

   // Shared multiplier: one 31-bit operand times one 16-bit operand
   always_comb begin
      case (ctl.big_sel)
         BIG_FG:     big_opd = fg_ff;
         BIG_SG:     big_opd = sg_ff;
         BIG_LAST:   big_opd = last_ff;
         BIG_BUCKET: big_opd = BUCKET_V;
         default:    big_opd = fg_ff;
      endcase
      case (ctl.small_sel)
         SML_MUL_A: small_opd = CLS_MUL_A;
         SML_MUL_B: small_opd = CLS_MUL_B;
         SML_RECIP: small_opd = RECIP_V;
         SML_QEST:  small_opd = CLS_MUL_W'(q_ff);
         default:   small_opd = CLS_MUL_A;
      endcase
   end

   assign prod_in = big_opd * small_opd;

   // Fold the upper product bits back in: 2^31 is congruent to a small constant
   assign fold_c  = ctl.fold_b ? CLS_FOLD_B : CLS_FOLD_A;
   assign hi_mul  = prod_ff[CLS_PROD_W-1:CLS_GEN_W] * fold_c;
   assign fold_in = {1'b0, prod_ff[CLS_GEN_W-1:0]} + {8'd0, hi_mul};

   // Folded value stays below twice the modulus: one compare and subtract
   assign mod_sel  = fold_b_ff ? CLS_MOD_B : CLS_MOD_A;
   assign red_wide = (fold_ff >= {1'b0, mod_sel}) ? (fold_ff - {1'b0, mod_sel}) : fold_ff;
   assign red      = red_wide[CLS_GEN_W-1:0];

   // Seed magnitude: saturate the most negative value, map zero to one
   assign seed_neg = ~seed_ff + CLS_SEED_W'(1);
   assign seed_abs = seed_ff[CLS_SEED_W-1] ? seed_neg : seed_ff;
   always_comb begin
      if (seed_abs[CLS_SEED_W-1]) begin
         seed_mag = '1;
      end else if (seed_abs == '0) begin
         seed_mag = CLS_GEN_W'(1);
      end else begin
         seed_mag = seed_abs[CLS_GEN_W-1:0];
      end
   end

   // Index estimate is low by at most one; bump it if last still reaches the next bucket
   assign bnd   = prod_ff[BND_W-1:0] + BND_W'(BUCKET_V);
   assign bump  = (BND_W'(last_ff) >= bnd);
   always_comb begin
      q_fix = {1'b0, q_ff} + (Q_W + 1)'(bump);
      if (q_fix >= (Q_W + 1)'(TABLE_SIZE)) begin
         q_fix = (Q_W + 1)'(TABLE_SIZE - 1);
      end
   end

   always_comb begin
      case (ctl.q_op)
         Q_EST:   q_in = prod_ff[CLS_GEN_W +: Q_W];
         Q_FIX:   q_in = q_fix[Q_W-1:0];
         default: q_in = q_ff;
      endcase
   end

   // Output word: table entry minus second generator, wrapped into range
   assign diff     = {2'b00, tbl_rd_data} - {2'b00, sg_ff};
   assign diff_alt = diff + (CLS_GEN_W + 2)'(CLS_OUT_MAX);
   assign y_val    = (diff[CLS_GEN_W+1] || diff == '0) ? diff_alt[CLS_GEN_W-1:0]
                                                      : diff[CLS_GEN_W-1:0];

   // Write-back
   always_comb begin
      fg_in         = fg_ff;
      sg_in         = sg_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      case (ctl.wb)
         WB_SEED: begin
            fg_in  = seed_mag;
            sg_in  = seed_mag;
            cnt_in = CNT_W'(WARMUP - 1);
         end
         WB_WARM: begin
            // last ends up equal to table entry zero after the final step
            fg_in   = red;
            last_in = red;
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         WB_GEN_A: begin
            fg_in = red;
         end
         WB_GEN_B: begin
            sg_in = red;
         end
         WB_OUT: begin
            last_in       = y_val;
            rsp_strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Table writes: warm-up fill at the step counter, draw swap at the index
   always_comb begin
      if (ctl.wb == WB_WARM) begin
         tbl_wr_en   = (cnt_ff < CNT_W'(TABLE_SIZE));
         tbl_wr_addr = cnt_ff[IDX_W-1:0];
         tbl_wr_data = red;
      end else begin
         tbl_wr_en   = ctl.tbl_wr;
         tbl_wr_addr = q_ff[IDX_W-1:0];
         tbl_wr_data = fg_ff;
      end
   end

   cls_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (ctl.tbl_rd),
      .rd_addr (q_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   // State with a defined reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff         <= '0;
         sg_ff         <= CLS_GEN_B_INIT;
         last_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fg_ff         <= fg_in;
         sg_ff         <= sg_in;
         last_ff       <= last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers: hold unless the step enables them
   always_ff @(posedge clock) begin
      if (go) begin
         seed_ff <= req_seed_value;
      end
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.fold_en) begin
         fold_ff   <= fold_in;
         fold_b_ff <= ctl.fold_b;
      end
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_random_value = last_ff;

endmodule

`default_nettype wire

### tb/tb_combined_lcg_shuffle_rng.sv
// Self-checking testbench for combined_lcg_shuffle_rng: seed and draw words go in,
// every drawn word is checked against a local model of the two generators and table.
// Depends on cls_pkg and the combined_lcg_shuffle_rng RTL.
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_rng;
   import cls_pkg::*;

   // Command codes on req_command
   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Generator constants; the Schrage quotient and remainder are m / mul and m % mul
   localparam longint MOD_A   = CLS_MOD_A;
   localparam longint MOD_B   = CLS_MOD_B;
   localparam longint MUL_A   = CLS_MUL_A;
   localparam longint MUL_B   = CLS_MUL_B;
   localparam longint QUO_A   = 53668;
   localparam longint QUO_B   = 52774;
   localparam longint REM_A   = 12211;
   localparam longint REM_B   = 3791;
   localparam longint OUT_MAX = CLS_OUT_MAX;
   localparam int     TBL_N   = CLS_TABLE_SIZE;
   localparam longint BUCKET  = 1 + OUT_MAX / TBL_N;
   localparam int     WARMUP  = TBL_N + 8;
   // Longest busy stretch (a seed) plus margin, used for the final settle
   localparam int     SETTLE_CYCLES = 1 + 3 * WARMUP + 10;

   typedef struct packed {
      logic                           command;
      logic signed [CLS_SEED_W-1:0]   seed;
   } cls_cmd_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_command;
   logic signed [CLS_SEED_W-1:0]   req_seed_value;
   logic                           rsp_strobe;
   logic [CLS_GEN_W-1:0]           rsp_random_value;

   combined_lcg_shuffle_rng i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_seed_value   (req_seed_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_random_value (rsp_random_value)
   );

   // Commands waiting to be driven, and drawn words still owed by the block
   cls_cmd_type          cmd_queue[$];
   logic [CLS_GEN_W-1:0] pending_words[$];

   int   sender_idle_pct = 31;
   int   errors = 0;
   logic req_taken;

   // Model state, starting from the reset values
   logic [CLS_GEN_W-1:0] gen_a = '0;
   logic [CLS_GEN_W-1:0] gen_b = CLS_GEN_B_INIT;
   logic [CLS_GEN_W-1:0] last_word = '0;
   logic [CLS_GEN_W-1:0] shuffle_tbl [TBL_N] = '{default: '0};

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------

   // One Lehmer step, (mul * x) mod m, by Schrage's method so no product overflows
   function automatic logic [CLS_GEN_W-1:0] lcg_step(input logic [CLS_GEN_W-1:0] x,
                                                    input longint mul, input longint quo,
                                                    input longint rem, input longint modulus);
      longint xs;
      longint k;
      longint v;
      xs = {33'd0, x};
      k  = xs / quo;
      v  = mul * (xs - k * quo) - k * rem;
      if (v < 0) v += modulus;
      return v[CLS_GEN_W-1:0];
   endfunction

   // Load both generators from the seed magnitude, then warm up and fill the table
   task automatic apply_seed(input logic [CLS_SEED_W-1:0] raw);
      longint mag;
      mag = {32'd0, raw};
      if (raw[CLS_SEED_W-1]) mag = 64'sh1_0000_0000 - mag;
      // most negative seed: magnitude saturates to the largest 31-bit value
      if (mag > 64'sd2147483647) mag = 64'sd2147483647;
      if (mag == 0) mag = 1;
      gen_a = mag[CLS_GEN_W-1:0];
      gen_b = mag[CLS_GEN_W-1:0];
      for (int j = WARMUP - 1; j >= 0; j--) begin
         gen_a = lcg_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
         if (j < TBL_N) shuffle_tbl[j] = gen_a;
      end
      last_word = shuffle_tbl[0];
   endtask

   // Step both generators, pick the table entry by the last word, swap in the new value
   function automatic logic [CLS_GEN_W-1:0] draw_word();
      longint idx;
      longint y;
      gen_a = lcg_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
      gen_b = lcg_step(gen_b, MUL_B, QUO_B, REM_B, MOD_B);
      idx = {33'd0, last_word} / BUCKET;
      if (idx >= TBL_N) idx = TBL_N - 1;
      y = longint'({33'd0, shuffle_tbl[idx]}) - longint'({33'd0, gen_b});
      shuffle_tbl[idx] = gen_a;
      if (y < 1) y += OUT_MAX;
      last_word = y[CLS_GEN_W-1:0];
      return last_word;
   endfunction

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Driver: present words at the falling edge; hold a word until it is taken
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_command    <= CMD_DRAW;
         req_seed_value <= '0;
      end else if (start && !req_taken) begin
         // hold: the block has not taken the current word yet
      end else if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
         req_command    <= cmd_queue[0].command;
         req_seed_value <= cmd_queue[0].seed;
         start          <= 1'b1;
         void'(cmd_queue.pop_front());
      end else begin
         start <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: at the rising edge check strobed words, then record accepted commands
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_strobe) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected random_value, expected none, got %0d",
                        $time, rsp_random_value);
               errors++;
            end else begin
               if (rsp_random_value !== pending_words[0]) begin
                  $display("%0t: random_value mismatch, expected %0d, got %0d",
                           $time, pending_words[0], rsp_random_value);
                  errors++;
               end
               void'(pending_words.pop_front());
            end
         end
         // advance the model on every accepted word; only draws owe a result
         if (start && !busy) begin
            if (req_command == CMD_SEED) apply_seed(req_seed_value);
            else pending_words.push_back(draw_word());
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic push_cmd(input logic command, input logic [CLS_SEED_W-1:0] seed);
      cls_cmd_type c;
      c.command = command;
      c.seed    = seed;
      cmd_queue.push_back(c);
   endtask

   // Mix full-range seeds, small magnitudes of either sign and the corner values
   function automatic logic [CLS_SEED_W-1:0] pick_seed();
      logic [CLS_SEED_W-1:0] corners [12];
      logic [CLS_SEED_W-1:0] s;
      corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0001, {1'b0, CLS_MOD_A}, -{1'b0, CLS_MOD_A},
                  {1'b0, CLS_MOD_B}, -{1'b0, CLS_MOD_B}, {1'b0, CLS_MOD_B} + 32'd1,
                  {1'b0, CLS_MOD_A} - 32'd1};
      case ($urandom_range(3))
         0, 1: begin
            s = $urandom;
         end
         2: begin
            s = $urandom_range(0, 1000);
            if ($urandom_range(1)) s = -s;
         end
         default: begin
            s = corners[$urandom_range(11)];
         end
      endcase
      return s;
   endfunction

   // Mostly seed-then-draws runs with random content; a few stray commands as noise
   task automatic queue_random_runs(input int count);
      int n;
      int draws;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 8) begin
            push_cmd(1'($urandom_range(1)), $urandom);
            n++;
         end else begin
            push_cmd(CMD_SEED, pick_seed());
            draws = $urandom_range(0, 12);
            for (int i = 0; i < draws; i++) push_cmd(CMD_DRAW, $urandom);
            n += draws + 1;
         end
      end
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || start || pending_words.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed: draws on the reset state, then each special seed followed by a draw
      push_cmd(CMD_DRAW, 32'h8000_0000);
      push_cmd(CMD_DRAW, 32'h7FFF_FFFF);
      push_cmd(CMD_SEED, 32'h0000_0000);           // zero becomes one
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, 32'h8000_0000);           // most negative seed saturates
      push_cmd(CMD_DRAW, 32'hFFFF_FFFF);
      push_cmd(CMD_SEED, 32'h7FFF_FFFF);           // above both moduli
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, {1'b0, CLS_MOD_A});       // first generator sticks at zero
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, {1'b0, CLS_MOD_B});       // second generator sticks at zero
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, -{1'b0, CLS_MOD_B});
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, {1'b0, CLS_MOD_B} + 32'd100); // between the two moduli
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, 32'hFFFF_FFFF);
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_SEED, 32'h0000_0001);
      push_cmd(CMD_DRAW, 32'h0000_0000);
      push_cmd(CMD_DRAW, 32'h0000_0000);

      // Random: three phases of sender pacing, the last with no gaps at all
      sender_idle_pct = 31;
      queue_random_runs(200);
      wait_drained();
      sender_idle_pct = 86;
      queue_random_runs(200);
      wait_drained();
      sender_idle_pct = 0;
      queue_random_runs(200);
      wait_drained();

      // Let a trailing seed finish and catch any stray strobe
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[combined_lcg_shuffle_rng] OK");
      end else begin
         $display("[combined_lcg_shuffle_rng] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("%0t: timeout", $time);
      $display("[combined_lcg_shuffle_rng] ERROR");
      $finish;
   end

endmodule
